// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define BCCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same, on the block clock and reset
`define BCCM_ASSERT_DEF(label, prop, msg) \
    `BCCM_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/bccm_pkg.sv =====
// shared types, codes and helper functions of the bank conflict cost monitor
`default_nettype none
package bccm_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTS       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_COST   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COST  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_MODEL  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST   = 4'd7;

    localparam logic [4:0]  SHIFT_MAX     = 5'd20;
    localparam logic [15:0] IL_DEFAULT    = 16'd4;
    localparam logic [63:0] SAT_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_BULK  = 2'd3
    } t_cmd;

    // number of quotient bits the divider produces
    typedef enum logic [1:0] {
        DIV_SHORT = 2'd0,   // 8 steps, quotient known below 256
        DIV_MID   = 2'd1,   // 32 steps, dividend below 2^32
        DIV_FULL  = 2'd2    // 64 steps
    } t_div_mode;

    typedef struct packed {
        logic        start;
        t_div_mode   mode;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } t_div_rsp;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SAT_MAX : s[63:0];
    endfunction

    function automatic logic [63:0] sat_mul9(input logic [63:0] a, input logic [8:0] b);
        logic [72:0] p;
        p = {9'd0, a} * {64'd0, b};
        return (|p[72:64]) ? SAT_MAX : p[63:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bank_conflict_cost_monitor_top.sv =====
// top level of the bank conflict cost monitor
`default_nettype none
// Bank conflict cost monitor. Takes one event request at a time (tick, read, write or
// bulk) tagged with a cycle number and keeps per-bank read and write counts of the
// current cycle in two 64-bit count memories, plus a per-bank list of read addresses
// for broadcast elision. When a request carries a new cycle number the finished cycle
// is scored bank by bank and one result request is emitted; that result then holds in
// an output register while the next event is already taken in. A sampled single read
// or write makes two 32-step passes through the shared serial divider (address over
// interleave, then modulo bank count), plus one compare per address slot walked when
// broadcast is on; a bulk request runs one division and one pass over the banks per
// non-zero half. A cycle roll runs the 8-step average-cost division for each bank
// with a non-zero count and, in the max model, also the 64-step rounds division.
// Counts are cleared on a roll through per-bank valid bits, so no clearing pass is
// needed. All counters saturate at 2^64-1.
module bank_conflict_cost_monitor_top #(
    parameter int MAX_BANKS  = 16,
    parameter int ADDR_SLOTS = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [bccm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [bccm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // event requests
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  [1:0]                        i_cmd,
    input  wire  [63:0]                       i_now_cycle,
    input  wire  [31:0]                       i_address,
    input  wire  [15:0]                       i_access_bytes,
    input  wire  [31:0]                       i_bulk_reads,
    input  wire  [31:0]                       i_bulk_writes,
    input  wire  [31:0]                       i_bulk_read_bytes,
    input  wire  [31:0]                       i_bulk_write_bytes,
    // result requests
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [63:0]                       o_cycle_extra,
    output logic                              o_cycle_had_conflict,
    output logic [63:0]                       o_cycle_overflow_accesses,
    output logic [63:0]                       o_peak_bank_accesses,
    output logic [63:0]                       o_extra_total,
    output logic [63:0]                       o_overflow_total,
    output logic [63:0]                       o_conflict_cycles_total,
    output logic [63:0]                       o_reads_seen_total,
    output logic [63:0]                       o_writes_seen_total,
    output logic [63:0]                       o_read_bytes_total,
    output logic [63:0]                       o_write_bytes_total,
    output logic [63:0]                       o_elided_total
);

    // widths that follow from the parameters
    localparam int BW = $clog2(MAX_BANKS + 1);                       // bank count
    localparam int BI = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;     // bank index
    localparam int SI = (ADDR_SLOTS > 1) ? $clog2(ADDR_SLOTS) : 1;   // slot index
    localparam int FW = $clog2(ADDR_SLOTS + 1);                      // fill count
    localparam int AD = MAX_BANKS * ADDR_SLOTS;
    localparam int AW = (AD > 1) ? $clog2(AD) : 1;                   // address store index

    typedef enum logic [22:0] {
        S_IDLE    = 23'h000001,
        S_SC_RD   = 23'h000002,
        S_SC_MUL  = 23'h000004,
        S_SC_CHK  = 23'h000008,
        S_SC_DIV1 = 23'h000010,
        S_SC_POST = 23'h000020,
        S_SC_SUM  = 23'h000040,
        S_SC_DIV2 = 23'h000080,
        S_SC_MAX  = 23'h000100,
        S_SC_NEXT = 23'h000200,
        S_SC_FIN  = 23'h000400,
        S_EMIT    = 23'h000800,
        S_BODY    = 23'h001000,
        S_BK1     = 23'h002000,
        S_BK2     = 23'h004000,
        S_BC_RD   = 23'h008000,
        S_BC_CMP  = 23'h010000,
        S_BC_MISS = 23'h020000,
        S_AC_RD   = 23'h040000,
        S_AC_WR   = 23'h080000,
        S_SP_DIV  = 23'h100000,
        S_SP_RD   = 23'h200000,
        S_SP_WR   = 23'h400000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [4:0]  r_cfg_bank_count;
    logic [7:0]  r_cfg_ports;
    logic [15:0] r_cfg_interleave;
    logic [7:0]  r_cfg_read_cost;
    logic [7:0]  r_cfg_write_cost;
    logic [4:0]  r_cfg_sample_shift;
    logic        r_cfg_cost_model;
    logic        r_cfg_broadcast;

    // effective settings after clamping
    logic [BW-1:0] eb;
    logic [7:0]    ports;
    logic [7:0]    rc;
    logic [7:0]    wc;
    logic [15:0]   il;
    logic [4:0]    sh;

    always_comb begin
        if (r_cfg_bank_count == 5'd0) begin
            eb = BW'(1);
        end else if (32'(r_cfg_bank_count) > MAX_BANKS) begin
            eb = BW'(MAX_BANKS);
        end else begin
            eb = BW'(r_cfg_bank_count);
        end
        ports = (r_cfg_ports == 8'd0) ? 8'd1 : r_cfg_ports;
        rc    = (r_cfg_read_cost == 8'd0) ? 8'd1 : r_cfg_read_cost;
        wc    = (r_cfg_write_cost == 8'd0) ? 8'd1 : r_cfg_write_cost;
        il    = (r_cfg_interleave == 16'd0) ? bccm_pkg::IL_DEFAULT : r_cfg_interleave;
        sh    = (r_cfg_sample_shift > bccm_pkg::SHIFT_MAX) ? bccm_pkg::SHIFT_MAX
                                                           : r_cfg_sample_shift;
    end

    // latched request
    bccm_pkg::t_cmd r_cmd;
    logic [63:0] r_now;
    logic [31:0] r_addr;
    logic [15:0] r_bytes;
    logic [31:0] r_bulk_rd;
    logic [31:0] r_bulk_wr;
    logic [31:0] r_bulk_rb;
    logic [31:0] r_bulk_wb;

    // cycle tracking and sampling
    logic        r_seen;
    logic [63:0] r_cur_cycle;
    logic [63:0] r_sample;
    logic [20:0] r_scale;
    logic [4:0]  r_sh;
    logic [BI-1:0] r_cursor;

    // running totals
    logic [63:0] r_tot_peak;
    logic [63:0] r_tot_extra;
    logic [63:0] r_tot_over;
    logic [63:0] r_tot_ccyc;
    logic [63:0] r_tot_rd;
    logic [63:0] r_tot_wr;
    logic [63:0] r_tot_rb;
    logic [63:0] r_tot_wb;
    logic [63:0] r_tot_el;

    // scoring scratch
    logic [BI-1:0] r_bank;
    logic [63:0]   r_total;
    logic [63:0]   r_pr;
    logic [63:0]   r_pw;
    logic [8:0]    r_avg;
    logic [63:0]   r_prod;
    logic [63:0]   r_extra;
    logic [63:0]   r_over_sum;
    logic [8:0]    r_base;
    logic [63:0]   r_maxreq;
    logic          r_has;

    // broadcast and spread scratch
    logic [SI-1:0] r_slot;
    logic          r_sp_wr;
    logic [31:0]   r_sp_q;
    logic [BW-1:0] r_sp_r;
    logic [BW-1:0] r_sp_cur;

    // result register
    logic        r_out_valid;
    logic [63:0] r_o_extra;
    logic        r_o_had;
    logic [63:0] r_o_over;
    logic [63:0] r_o_peak;
    logic [63:0] r_o_tot_extra;
    logic [63:0] r_o_tot_over;
    logic [63:0] r_o_tot_ccyc;
    logic [63:0] r_o_tot_rd;
    logic [63:0] r_o_tot_wr;
    logic [63:0] r_o_tot_rb;
    logic [63:0] r_o_tot_wb;
    logic [63:0] r_o_tot_el;

    // shared divider
    bccm_pkg::t_div_req r_div;
    bccm_pkg::t_div_rsp div_rsp;

    bccm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div),
        .o_rsp   (div_rsp)
    );

    // per-bank count memories; an entry not written since the last roll reads as zero
    logic [63:0] rd_mem [MAX_BANKS];
    logic [63:0] wr_mem [MAX_BANKS];
    logic [MAX_BANKS-1:0] r_rd_vld;
    logic [MAX_BANKS-1:0] r_wr_vld;
    logic [63:0] r_rd_q;
    logic [63:0] r_wr_q;
    logic        r_rd_q_v;
    logic        r_wr_q_v;

    // per-bank read address lists
    logic [31:0]   addr_mem [AD];
    logic [31:0]   r_addr_q;
    logic [FW-1:0] r_fill [MAX_BANKS];

    logic          mem_re;
    logic          rd_we;
    logic          wr_we;
    logic [63:0]   rd_val;
    logic [63:0]   wr_val;
    logic [63:0]   tgt_val;
    logic [63:0]   mem_wdata;
    logic          am_re;
    logic          am_we;
    logic [AW-1:0] am_ridx;
    logic [AW-1:0] am_widx;
    logic [FW-1:0] cur_fill;

    // spread helpers
    logic [BW:0]   cur_mod;
    logic [BW:0]   rr_dist;
    logic          rr_inc;
    logic [BW:0]   cur_next;
    logic [BW:0]   bank_next;

    // roll scoring helpers
    logic [63:0]   total_c;
    logic [63:0]   fin_extra;
    logic [63:0]   cyc_scale;

    always_comb begin
        rd_val  = r_rd_q_v ? r_rd_q : 64'd0;
        wr_val  = r_wr_q_v ? r_wr_q : 64'd0;
        total_c = bccm_pkg::sat_add(rd_val, wr_val);
        mem_re  = (r_state == S_SC_RD) || (r_state == S_AC_RD) || (r_state == S_SP_RD);
        rd_we   = ((r_state == S_AC_WR) && (r_cmd == bccm_pkg::CMD_READ))
                  || ((r_state == S_SP_WR) && !r_sp_wr);
        wr_we   = ((r_state == S_AC_WR) && (r_cmd == bccm_pkg::CMD_WRITE))
                  || ((r_state == S_SP_WR) && r_sp_wr);
        tgt_val = rd_we ? rd_val : wr_val;

        // cursor modulo bank count, restoring one bit per step
        cur_mod = '0;
        for (int i = BI - 1; i >= 0; i--) begin
            cur_mod = {cur_mod[BW-1:0], r_cursor[i]};
            if (cur_mod >= {1'b0, eb}) begin
                cur_mod = cur_mod - {1'b0, eb};
            end
        end

        // round-robin: bank gets one more when its distance from the cursor is below r
        if ({1'b0, (BW)'(r_bank)} >= {1'b0, r_sp_cur}) begin
            rr_dist = {1'b0, BW'(r_bank)} - {1'b0, r_sp_cur};
        end else begin
            rr_dist = {1'b0, BW'(r_bank)} + {1'b0, eb} - {1'b0, r_sp_cur};
        end
        rr_inc   = rr_dist < {1'b0, r_sp_r};
        cur_next = {1'b0, r_sp_cur} + {1'b0, r_sp_r};
        if (cur_next >= {1'b0, eb}) begin
            cur_next = cur_next - {1'b0, eb};
        end
        bank_next = {1'b0, BW'(r_bank)} + (BW+1)'(1);

        cyc_scale = 64'(r_scale);
        if (r_state == S_AC_WR) begin
            mem_wdata = bccm_pkg::sat_add(tgt_val, cyc_scale);
        end else begin
            mem_wdata = bccm_pkg::sat_add(tgt_val, 64'(r_sp_q) + 64'(rr_inc));
        end

        cur_fill = r_fill[r_bank];
        am_re    = (r_state == S_BC_RD);
        am_we    = (r_state == S_BC_MISS) && (32'(cur_fill) < ADDR_SLOTS);
        am_ridx  = AW'(32'(r_bank) * ADDR_SLOTS + 32'(r_slot));
        am_widx  = AW'(32'(r_bank) * ADDR_SLOTS + 32'(cur_fill));

        if (r_cfg_cost_model) begin
            fin_extra = (r_maxreq > 64'(r_base)) ? r_maxreq - 64'(r_base) : 64'd0;
        end else begin
            fin_extra = r_extra;
        end
    end

    // count memories: one read or write a cycle
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_q   <= rd_mem[r_bank];
            r_wr_q   <= wr_mem[r_bank];
            r_rd_q_v <= r_rd_vld[r_bank];
            r_wr_q_v <= r_wr_vld[r_bank];
        end
        if (rd_we) begin
            rd_mem[r_bank] <= mem_wdata;
        end
        if (wr_we) begin
            wr_mem[r_bank] <= mem_wdata;
        end
    end

    // address list memory
    always_ff @(posedge i_clk) begin
        if (am_re) begin
            r_addr_q <= addr_mem[am_ridx];
        end
        if (am_we) begin
            addr_mem[am_widx] <= r_addr;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_cfg_bank_count   <= 5'd1;
            r_cfg_ports        <= 8'd1;
            r_cfg_interleave   <= 16'd4;
            r_cfg_read_cost    <= 8'd1;
            r_cfg_write_cost   <= 8'd1;
            r_cfg_sample_shift <= 5'd0;
            r_cfg_cost_model   <= 1'b0;
            r_cfg_broadcast    <= 1'b0;
            r_seen             <= 1'b0;
            r_cur_cycle        <= '0;
            r_sample           <= '0;
            r_cursor           <= '0;
            r_tot_peak         <= '0;
            r_tot_extra        <= '0;
            r_tot_over         <= '0;
            r_tot_ccyc         <= '0;
            r_tot_rd           <= '0;
            r_tot_wr           <= '0;
            r_tot_rb           <= '0;
            r_tot_wb           <= '0;
            r_tot_el           <= '0;
            r_rd_vld           <= '0;
            r_wr_vld           <= '0;
            for (int b = 0; b < MAX_BANKS; b++) begin
                r_fill[b] <= '0;
            end
            r_out_valid        <= 1'b0;
            r_div.start        <= 1'b0;
        end else begin
            r_div.start <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bccm_pkg::CFG_BANK_COUNT: r_cfg_bank_count   <= i_cfg_data[4:0];
                    bccm_pkg::CFG_PORTS:      r_cfg_ports        <= i_cfg_data[7:0];
                    bccm_pkg::CFG_INTERLEAVE: r_cfg_interleave   <= i_cfg_data;
                    bccm_pkg::CFG_READ_COST:  r_cfg_read_cost    <= i_cfg_data[7:0];
                    bccm_pkg::CFG_WRITE_COST: r_cfg_write_cost   <= i_cfg_data[7:0];
                    bccm_pkg::CFG_SAMPLE:     r_cfg_sample_shift <= i_cfg_data[4:0];
                    bccm_pkg::CFG_COST_MODEL: r_cfg_cost_model   <= i_cfg_data[0];
                    bccm_pkg::CFG_BROADCAST:  r_cfg_broadcast    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (rd_we) begin
                r_rd_vld[r_bank] <= 1'b1;
            end
            if (wr_we) begin
                r_wr_vld[r_bank] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= bccm_pkg::t_cmd'(i_cmd);
                        r_now     <= i_now_cycle;
                        r_addr    <= i_address;
                        r_bytes   <= i_access_bytes;
                        r_bulk_rd <= i_bulk_reads;
                        r_bulk_wr <= i_bulk_writes;
                        r_bulk_rb <= i_bulk_read_bytes;
                        r_bulk_wb <= i_bulk_write_bytes;
                        if (!r_seen) begin
                            // first event only opens the cycle
                            r_seen      <= 1'b1;
                            r_cur_cycle <= i_now_cycle;
                            r_state     <= S_BODY;
                        end else if (i_now_cycle != r_cur_cycle) begin
                            r_bank     <= '0;
                            r_extra    <= '0;
                            r_over_sum <= '0;
                            r_base     <= '0;
                            r_maxreq   <= '0;
                            r_has      <= 1'b0;
                            r_state    <= S_SC_RD;
                        end else begin
                            r_state <= S_BODY;
                        end
                    end
                end

                // ---- score the finished cycle, one bank at a time ----
                S_SC_RD: r_state <= S_SC_MUL;
                S_SC_MUL: begin
                    r_total <= total_c;
                    r_pr    <= bccm_pkg::sat_mul9(rd_val, {1'b0, rc});
                    r_pw    <= bccm_pkg::sat_mul9(wr_val, {1'b0, wc});
                    if (total_c > r_tot_peak) begin
                        r_tot_peak <= total_c;
                    end
                    r_state <= S_SC_CHK;
                end
                S_SC_CHK: begin
                    if (r_total == 64'd0) begin
                        r_state <= S_SC_NEXT;
                    end else begin
                        // weighted cost never exceeds 255 * total: 8 quotient bits
                        r_div.start    <= 1'b1;
                        r_div.mode     <= bccm_pkg::DIV_SHORT;
                        r_div.dividend <= bccm_pkg::sat_add(r_pr, r_pw);
                        r_div.divisor  <= r_total;
                        r_state        <= S_SC_DIV1;
                    end
                end
                S_SC_DIV1: begin
                    if (div_rsp.done) begin
                        r_avg <= 9'(div_rsp.quot[7:0]) + 9'(div_rsp.rem != 64'd0);
                        if ((div_rsp.quot[7:0] == 8'd0) && (div_rsp.rem == 64'd0)) begin
                            r_avg <= 9'd1;
                        end
                        r_state <= S_SC_POST;
                    end
                end
                S_SC_POST: begin
                    if (r_total > 64'(ports)) begin
                        r_has      <= 1'b1;
                        r_over_sum <= bccm_pkg::sat_add(r_over_sum, r_total - 64'(ports));
                        r_prod     <= bccm_pkg::sat_mul9(r_total - 64'(ports), r_avg);
                    end else begin
                        r_prod <= '0;
                    end
                    if (r_cfg_cost_model) begin
                        r_div.start    <= 1'b1;
                        r_div.mode     <= bccm_pkg::DIV_FULL;
                        r_div.dividend <= r_total;
                        r_div.divisor  <= 64'(ports);
                        r_state        <= S_SC_DIV2;
                    end else begin
                        r_state <= S_SC_SUM;
                    end
                end
                S_SC_SUM: begin
                    r_extra <= bccm_pkg::sat_add(r_extra, r_prod);
                    r_state <= S_SC_NEXT;
                end
                S_SC_DIV2: begin
                    if (div_rsp.done) begin
                        r_prod  <= bccm_pkg::sat_mul9(
                                       div_rsp.quot + 64'(div_rsp.rem != 64'd0), r_avg);
                        r_state <= S_SC_MAX;
                    end
                end
                S_SC_MAX: begin
                    if (r_prod > r_maxreq) begin
                        r_maxreq <= r_prod;
                    end
                    if (r_avg > r_base) begin
                        r_base <= r_avg;
                    end
                    r_state <= S_SC_NEXT;
                end
                S_SC_NEXT: begin
                    if (bank_next < {1'b0, eb}) begin
                        r_bank  <= BI'(bank_next);
                        r_state <= S_SC_RD;
                    end else begin
                        r_state <= S_SC_FIN;
                    end
                end
                S_SC_FIN: begin
                    r_extra     <= fin_extra;
                    r_tot_extra <= bccm_pkg::sat_add(r_tot_extra, fin_extra);
                    r_tot_over  <= bccm_pkg::sat_add(r_tot_over, r_over_sum);
                    if (r_has) begin
                        r_tot_ccyc <= bccm_pkg::sat_add(r_tot_ccyc, 64'd1);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // wait for the result register to free up
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_o_extra     <= r_extra;
                        r_o_had       <= r_has;
                        r_o_over      <= r_over_sum;
                        r_o_peak      <= r_tot_peak;
                        r_o_tot_extra <= r_tot_extra;
                        r_o_tot_over  <= r_tot_over;
                        r_o_tot_ccyc  <= r_tot_ccyc;
                        r_o_tot_rd    <= r_tot_rd;
                        r_o_tot_wr    <= r_tot_wr;
                        r_o_tot_rb    <= r_tot_rb;
                        r_o_tot_wb    <= r_tot_wb;
                        r_o_tot_el    <= r_tot_el;
                        r_cur_cycle   <= r_now;
                        r_rd_vld      <= '0;
                        r_wr_vld      <= '0;
                        for (int b = 0; b < MAX_BANKS; b++) begin
                            r_fill[b] <= '0;
                        end
                        r_state <= S_BODY;
                    end
                end

                // ---- event body ----
                S_BODY: begin
                    case (r_cmd)
                        bccm_pkg::CMD_READ, bccm_pkg::CMD_WRITE: begin
                            r_sh <= sh;
                            if (sh == 5'd0) begin
                                r_scale <= 21'd1;
                            end else begin
                                r_sample <= bccm_pkg::sat_add(r_sample, 64'd1);
                                r_scale  <= 21'd1 << sh;
                            end
                            if ((sh == 5'd0)
                                || ((r_sample & ((64'd1 << sh) - 64'd1)) == 64'd0)) begin
                                r_div.start    <= 1'b1;
                                r_div.mode     <= bccm_pkg::DIV_MID;
                                r_div.dividend <= 64'(r_addr);
                                r_div.divisor  <= 64'(il);
                                r_state        <= S_BK1;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        bccm_pkg::CMD_BULK: begin
                            if (r_bulk_rd != 32'd0) begin
                                r_tot_rd       <= bccm_pkg::sat_add(r_tot_rd, 64'(r_bulk_rd));
                                r_tot_rb       <= bccm_pkg::sat_add(r_tot_rb, 64'(r_bulk_rb));
                                r_sp_wr        <= 1'b0;
                                r_div.start    <= 1'b1;
                                r_div.mode     <= bccm_pkg::DIV_MID;
                                r_div.dividend <= 64'(r_bulk_rd);
                                r_div.divisor  <= 64'(eb);
                                r_state        <= S_SP_DIV;
                            end else if (r_bulk_wr != 32'd0) begin
                                r_tot_wr       <= bccm_pkg::sat_add(r_tot_wr, 64'(r_bulk_wr));
                                r_tot_wb       <= bccm_pkg::sat_add(r_tot_wb, 64'(r_bulk_wb));
                                r_sp_wr        <= 1'b1;
                                r_div.start    <= 1'b1;
                                r_div.mode     <= bccm_pkg::DIV_MID;
                                r_div.dividend <= 64'(r_bulk_wr);
                                r_div.divisor  <= 64'(eb);
                                r_state        <= S_SP_DIV;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end

                // bank = (address / interleave) % banks
                S_BK1: begin
                    if (div_rsp.done) begin
                        r_div.start    <= 1'b1;
                        r_div.mode     <= bccm_pkg::DIV_MID;
                        r_div.dividend <= {32'd0, div_rsp.quot[31:0]};
                        r_div.divisor  <= 64'(eb);
                        r_state        <= S_BK2;
                    end
                end
                S_BK2: begin
                    if (div_rsp.done) begin
                        r_bank <= BI'(div_rsp.rem);
                        r_slot <= '0;
                        if ((r_cmd == bccm_pkg::CMD_READ) && r_cfg_broadcast) begin
                            if (r_fill[BI'(div_rsp.rem)] == '0) begin
                                r_state <= S_BC_MISS;
                            end else begin
                                r_state <= S_BC_RD;
                            end
                        end else begin
                            r_state <= S_AC_RD;
                        end
                    end
                end

                // broadcast: walk the bank's address list
                S_BC_RD: r_state <= S_BC_CMP;
                S_BC_CMP: begin
                    if (r_addr_q == r_addr) begin
                        r_tot_el <= bccm_pkg::sat_add(r_tot_el, cyc_scale);
                        r_state  <= S_IDLE;
                    end else if ((FW+1)'(r_slot) + (FW+1)'(1) < {1'b0, cur_fill}) begin
                        r_slot  <= r_slot + SI'(1);
                        r_state <= S_BC_RD;
                    end else begin
                        r_state <= S_BC_MISS;
                    end
                end
                S_BC_MISS: begin
                    if (am_we) begin
                        r_fill[r_bank] <= cur_fill + FW'(1);
                    end
                    r_state <= S_AC_RD;
                end

                // single access: read-modify-write of one bank count
                S_AC_RD: r_state <= S_AC_WR;
                S_AC_WR: begin
                    if (r_cmd == bccm_pkg::CMD_READ) begin
                        r_tot_rd <= bccm_pkg::sat_add(r_tot_rd, cyc_scale);
                        r_tot_rb <= bccm_pkg::sat_add(r_tot_rb, 64'(r_bytes) << r_sh);
                    end else begin
                        r_tot_wr <= bccm_pkg::sat_add(r_tot_wr, cyc_scale);
                        r_tot_wb <= bccm_pkg::sat_add(r_tot_wb, 64'(r_bytes) << r_sh);
                    end
                    r_state <= S_IDLE;
                end

                // bulk spread: quotient to every bank, remainder round-robin
                S_SP_DIV: begin
                    if (div_rsp.done) begin
                        r_sp_q   <= div_rsp.quot[31:0];
                        r_sp_r   <= BW'(div_rsp.rem);
                        r_sp_cur <= BW'(cur_mod);
                        r_bank   <= '0;
                        r_state  <= S_SP_RD;
                    end
                end
                S_SP_RD: r_state <= S_SP_WR;
                S_SP_WR: begin
                    if (bank_next < {1'b0, eb}) begin
                        r_bank  <= BI'(bank_next);
                        r_state <= S_SP_RD;
                    end else begin
                        r_cursor <= BI'(cur_next);
                        if (!r_sp_wr && (r_bulk_wr != 32'd0)) begin
                            r_tot_wr       <= bccm_pkg::sat_add(r_tot_wr, 64'(r_bulk_wr));
                            r_tot_wb       <= bccm_pkg::sat_add(r_tot_wb, 64'(r_bulk_wb));
                            r_sp_wr        <= 1'b1;
                            r_div.start    <= 1'b1;
                            r_div.mode     <= bccm_pkg::DIV_MID;
                            r_div.dividend <= 64'(r_bulk_wr);
                            r_div.divisor  <= 64'(eb);
                            r_state        <= S_SP_DIV;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid               = r_out_valid;
    assign o_cycle_extra             = r_o_extra;
    assign o_cycle_had_conflict      = r_o_had;
    assign o_cycle_overflow_accesses = r_o_over;
    assign o_peak_bank_accesses      = r_o_peak;
    assign o_extra_total             = r_o_tot_extra;
    assign o_overflow_total          = r_o_tot_over;
    assign o_conflict_cycles_total   = r_o_tot_ccyc;
    assign o_reads_seen_total        = r_o_tot_rd;
    assign o_writes_seen_total       = r_o_tot_wr;
    assign o_read_bytes_total        = r_o_tot_rb;
    assign o_write_bytes_total       = r_o_tot_wb;
    assign o_elided_total            = r_o_tot_el;

endmodule
`default_nettype wire

// ===== rtl/bccm_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module bccm_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bccm_pkg::t_div_req  i_req,
    output bccm_pkg::t_div_rsp  o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_dq;
    logic [63:0] r_div;

    logic [64:0] trial;
    logic        ge;
    logic [63:0] n_rem;
    logic [63:0] n_dq;

    always_comb begin
        trial = {r_rem, r_dq[63]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? 64'(trial - {1'b0, r_div}) : trial[63:0];
        n_dq  = {r_dq[62:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.divisor;
                unique case (i_req.mode)
                    bccm_pkg::DIV_SHORT: begin
                        r_rem <= {8'd0, i_req.dividend[63:8]};
                        r_dq  <= {i_req.dividend[7:0], 56'd0};
                        r_cnt <= 7'd8;
                    end
                    bccm_pkg::DIV_MID: begin
                        r_rem <= {32'd0, i_req.dividend[63:32]};
                        r_dq  <= {i_req.dividend[31:0], 32'd0};
                        r_cnt <= 7'd32;
                    end
                    default: begin
                        r_rem <= '0;
                        r_dq  <= i_req.dividend;
                        r_cnt <= 7'd64;
                    end
                endcase
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dq  <= n_dq;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dq;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

// ===== rtl/bccm_checker.sv =====
// port-level checker of the bank conflict cost monitor and its bind
`default_nettype none
`include "assert_macros.svh"
module bccm_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_cfg_valid,
    input wire                             o_cfg_ready,
    input wire [bccm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input wire [bccm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input wire                             i_in_valid,
    input wire                             o_in_stall,
    input wire [1:0]                       i_cmd,
    input wire [63:0]                      i_now_cycle,
    input wire [31:0]                      i_address,
    input wire [15:0]                      i_access_bytes,
    input wire [31:0]                      i_bulk_reads,
    input wire [31:0]                      i_bulk_writes,
    input wire [31:0]                      i_bulk_read_bytes,
    input wire [31:0]                      i_bulk_write_bytes,
    input wire                             o_out_valid,
    input wire                             i_out_stall,
    input wire [63:0]                      o_cycle_extra,
    input wire                             o_cycle_had_conflict,
    input wire [63:0]                      o_cycle_overflow_accesses,
    input wire [63:0]                      o_peak_bank_accesses,
    input wire [63:0]                      o_extra_total,
    input wire [63:0]                      o_overflow_total,
    input wire [63:0]                      o_conflict_cycles_total,
    input wire [63:0]                      o_reads_seen_total,
    input wire [63:0]                      o_writes_seen_total,
    input wire [63:0]                      o_read_bytes_total,
    input wire [63:0]                      o_write_bytes_total,
    input wire [63:0]                      o_elided_total
);

    // a stalled result stays put
    `BCCM_ASSERT_DEF(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_extra_total), "stalled result changed")

    // running totals already include the cycle just scored
    `BCCM_ASSERT_DEF(a_extra_incl, o_out_valid |-> o_extra_total >= o_cycle_extra, "extra total below cycle extra")

    `BCCM_ASSERT_DEF(a_over_incl, o_out_valid |-> o_overflow_total >= o_cycle_overflow_accesses, "overflow total below cycle overflow")

    `BCCM_ASSERT_DEF(a_ccyc_counted, o_out_valid && o_cycle_had_conflict |-> o_conflict_cycles_total != 64'd0, "conflict cycle not counted")

    // no conflict means no bank went past its ports
    `BCCM_ASSERT_DEF(a_quiet_cycle, o_out_valid && !o_cycle_had_conflict |-> o_cycle_overflow_accesses == 64'd0, "overflow without conflict")

endmodule

bind bank_conflict_cost_monitor_top bccm_checker u_bccm_checker (.*);
`default_nettype wire
